// ===== sv/gost_pkg.sv =====
// ----------------------------------------------------------------------------
// GOST R 34.11-94 hash package
// Shared types, constants, the cipher round function and the A, P and psi transforms.
// ----------------------------------------------------------------------------
package gost_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] blk_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_KEY,
      ST_ROUND,
      ST_PSI,
      ST_PAD,
      ST_LEN,
      ST_SUM,
      ST_OUT
   } state_type;

   // psi shuffle schedule: 12, then xor m, 1, then xor h, 61
   localparam logic [6:0] PSI_A = 7'd12;
   localparam logic [6:0] PSI_B = 7'd61;

   localparam blk_type C3_WORDS = '{
      32'hff00ffff, 32'h000000ff, 32'hff0000ff, 32'h00ffff00,
      32'h00ff00ff, 32'h00ff00ff, 32'hff00ff00, 32'hff00ff00};

   function automatic logic [3:0] sb(input logic [2:0] n, input logic [3:0] x);
      logic [3:0] t [8][16];
      t = '{
         '{4'd10,4'd4,4'd5,4'd6,4'd8,4'd1,4'd3,4'd7,4'd13,4'd12,4'd14,4'd0,4'd9,4'd2,4'd11,4'd15},
         '{4'd5,4'd15,4'd4,4'd0,4'd2,4'd13,4'd11,4'd9,4'd1,4'd7,4'd6,4'd3,4'd12,4'd14,4'd10,4'd8},
         '{4'd7,4'd15,4'd12,4'd14,4'd9,4'd4,4'd1,4'd0,4'd3,4'd11,4'd5,4'd2,4'd6,4'd10,4'd8,4'd13},
         '{4'd4,4'd10,4'd7,4'd12,4'd0,4'd15,4'd2,4'd8,4'd14,4'd1,4'd6,4'd5,4'd13,4'd11,4'd9,4'd3},
         '{4'd7,4'd6,4'd4,4'd11,4'd9,4'd12,4'd2,4'd10,4'd1,4'd8,4'd0,4'd14,4'd15,4'd13,4'd3,4'd5},
         '{4'd7,4'd6,4'd2,4'd4,4'd13,4'd9,4'd15,4'd0,4'd10,4'd1,4'd5,4'd11,4'd8,4'd14,4'd12,4'd3},
         '{4'd13,4'd14,4'd4,4'd1,4'd7,4'd0,4'd5,4'd10,4'd3,4'd12,4'd8,4'd15,4'd6,4'd2,4'd9,4'd11},
         '{4'd1,4'd3,4'd10,4'd9,4'd5,4'd11,4'd4,4'd15,4'd8,4'd6,4'd7,4'd14,4'd13,4'd0,4'd2,4'd12}};
      return t[n][x];
   endfunction

   function automatic word_type round_fn(input word_type half, input word_type k);
      word_type x;
      word_type y;
      x = half + k;
      for (int n = 0; n < 8; n++) begin
         y[4*n +: 4] = sb(3'(n), x[4*n +: 4]);
      end
      return {y[20:0], y[31:21]};
   endfunction

   function automatic blk_type a_xform(input blk_type y);
      blk_type r;
      for (int i = 0; i < 6; i++) begin
         r[i] = y[i+2];
      end
      r[6] = y[0] ^ y[2];
      r[7] = y[1] ^ y[3];
      return r;
   endfunction

   function automatic blk_type p_xform(input blk_type w);
      blk_type key;
      for (int a = 0; a < 2; a++) begin
         for (int b = 0; b < 4; b++) begin
            for (int c = 0; c < 4; c++) begin
               key[a*4+b][8*c +: 8] = w[2*c+a][8*b +: 8];
            end
         end
      end
      return key;
   endfunction

   function automatic blk_type psi_xform(input blk_type w);
      blk_type r;
      logic [15:0] t;
      t = w[0][15:0] ^ w[0][31:16] ^ w[1][15:0] ^ w[1][31:16] ^ w[6][15:0] ^ w[7][31:16];
      for (int i = 0; i < 7; i++) begin
         r[i] = {w[i+1][15:0], w[i][31:16]};
      end
      r[7] = {t, w[7][31:16]};
      return r;
   endfunction

endpackage

// ===== sv/gost_cipher.sv =====
// ----------------------------------------------------------------------------
// GOST cipher round unit
// One 28147-89 round a cycle; 32 rounds per encryption.
// ----------------------------------------------------------------------------
module gost_cipher import gost_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  blk_type  key,
   input  word_type in_lo,
   input  word_type in_hi,
   output logic     done,
   output word_type out_lo,
   output word_type out_hi
);

   word_type   a_ff, a_in, b_ff, b_in;
   logic [4:0] rnd_ff, rnd_in;
   logic       busy_ff, busy_in;
   logic [2:0] kidx;
   word_type   f;

   always_comb begin
      kidx = (rnd_ff < 5'd24) ? rnd_ff[2:0] : 3'd7 - rnd_ff[2:0];
      f = round_fn(rnd_ff[0] ? b_ff : a_ff, key[kidx]);
      a_in = a_ff;
      b_in = b_ff;
      rnd_in = rnd_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in = in_lo;
         b_in = in_hi;
         rnd_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rnd_ff[0]) begin
            a_in = a_ff ^ f;
         end else begin
            b_in = b_ff ^ f;
         end
         rnd_in = rnd_ff + 5'd1;
         if (rnd_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // last round is odd: b is final, a takes its last update
   assign done   = busy_ff && rnd_ff == 5'd31;
   assign out_lo = b_ff;
   assign out_hi = a_ff ^ f;

endmodule

// ===== sv/gost_r3411_94_hash_top.sv =====
// ----------------------------------------------------------------------------
// GOST R 34.11-94 hash top level
// Collects bytes into 32-byte blocks, compresses them, emits the digest.
// ----------------------------------------------------------------------------
// Flow: a request holds req_stall while its bytes are absorbed (one byte a
// cycle, paused while a full block is compressed) and for one closing step;
// each block adds a sum step, 4 x (key step + 32 cipher rounds) and 75 psi steps at one a cycle.
// Finalisation runs up to three compressions, then four digest responses.
// Throughput: one request at a time; req_stall is high while busy.
// Reset: synchronous, active high; clears chain value, sum, buffer, count.
module gost_r3411_94_hash_top import gost_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part,
   output logic [1:0]  rsp_part_index,
   output logic        rsp_last_part
);

   state_type   state_ff, state_in;
   blk_type     h_ff, h_in, sum_ff, sum_in, m_ff, m_in;
   blk_type     u_ff, u_in, v_ff, v_in, key_ff, key_in, s_ff, s_in;
   logic [255:0] buf_ff, buf_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic [1:0]  j_ff, j_in;
   logic [6:0]  psi_ff, psi_in;
   logic [1:0]  phase_ff, phase_in;   // 0 data block, 1 len, 2 sum, 3 padded last block
   logic [1:0]  part_ff, part_in;
   logic        c_start, c_done;
   word_type    c_lo, c_hi;
   word_type    cin_lo, cin_hi;
   blk_type     w;
   logic [32:0] acc;
   logic        carry;

   gost_cipher u_cipher (
      .clock(clock), .reset(reset), .start(c_start), .key(key_ff),
      .in_lo(cin_lo), .in_hi(cin_hi), .done(c_done), .out_lo(c_lo), .out_hi(c_hi));

   assign cin_lo = h_ff[{j_ff, 1'b0}];
   assign cin_hi = h_ff[{j_ff, 1'b1}];
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_digest_part = {h_ff[{part_ff, 1'b1}], h_ff[{part_ff, 1'b0}]};
   assign rsp_part_index = part_ff;
   assign rsp_last_part = part_ff == 2'd3;

   always_comb begin
      state_in = state_ff; h_in = h_ff; sum_in = sum_ff; m_in = m_ff;
      u_in = u_ff; v_in = v_ff; key_in = key_ff; s_in = s_ff;
      buf_in = buf_ff; total_in = total_ff; data_in = data_ff; cnt_in = cnt_ff;
      fin_in = fin_ff; j_in = j_ff; psi_in = psi_ff; phase_in = phase_ff;
      part_in = part_ff; c_start = 1'b0; w = u_ff ^ v_ff; acc = '0; carry = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               data_in = req_data_word;
               cnt_in = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
               fin_in = req_last;
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            // one byte a cycle; full block goes to compression
            if (cnt_ff != 4'd0) begin
               buf_in[{total_ff[4:0], 3'b000} +: 8] = data_ff[7:0];
               data_in = data_ff >> 8;
               cnt_in = cnt_ff - 4'd1;
               total_in = total_ff + 64'd1;
               if (total_ff[4:0] == 5'd31) begin
                  state_in = ST_PAD;
               end
            end else if (fin_ff) begin
               if (total_ff[4:0] != 5'd0) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_LEN;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // block from buffer (zero tail already), add into sum
            for (int i = 0; i < 8; i++) begin
               acc = {1'b0, sum_ff[i]} + {1'b0, buf_ff[32*i +: 32]} + {32'd0, carry};
               sum_in[i] = acc[31:0];
               carry = acc[32];
               m_in[i] = buf_ff[32*i +: 32];
               v_in[i] = buf_ff[32*i +: 32];
            end
            buf_in = '0;
            u_in = h_ff; j_in = '0;
            // a part-filled block only comes here on the last request
            phase_in = (total_ff[4:0] == 5'd0) ? 2'd0 : 2'd3;
            state_in = ST_KEY;
         end
         ST_LEN: begin
            m_in = '0;
            m_in[0] = {total_ff[28:0], 3'b000};
            m_in[1] = total_ff[60:29];
            v_in = m_in; u_in = h_ff; j_in = '0; phase_in = 2'd1;
            state_in = ST_KEY;
         end
         ST_SUM: begin
            m_in = sum_ff; v_in = sum_ff; u_in = h_ff; j_in = '0; phase_in = 2'd2;
            state_in = ST_KEY;
         end
         ST_KEY: begin
            key_in = p_xform(w);
            c_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (c_done) begin
               s_in[{j_ff, 1'b0}] = c_lo;
               s_in[{j_ff, 1'b1}] = c_hi;
               j_in = j_ff + 2'd1;
               u_in = (j_ff == 2'd1) ? (a_xform(u_ff) ^ C3_WORDS) : a_xform(u_ff);
               v_in = a_xform(a_xform(v_ff));
               psi_in = '0;
               state_in = (j_ff == 2'd3) ? ST_PSI : ST_KEY;
            end
         end
         ST_PSI: begin
            psi_in = psi_ff + 7'd1;
            if (psi_ff == PSI_A) begin
               s_in = psi_xform(s_ff ^ m_ff);
            end else if (psi_ff == PSI_A + 7'd1) begin
               s_in = psi_xform(s_ff ^ h_ff);
            end else begin
               s_in = psi_xform(s_ff);
            end
            if (psi_ff == PSI_A + 7'd1 + PSI_B) begin
               s_in = s_ff;
               h_in = s_ff;
               unique case (phase_ff)
                  2'd0: state_in = ST_ABSORB;
                  2'd1: state_in = ST_SUM;
                  2'd2: begin
                     part_in = '0;
                     state_in = ST_OUT;
                  end
                  2'd3: state_in = ST_LEN;
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  h_in = '0; sum_in = '0; buf_in = '0; total_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; u_ff <= u_in; v_ff <= v_in; key_ff <= key_in; s_ff <= s_in;
      data_ff <= data_in; cnt_ff <= cnt_in; fin_ff <= fin_in;
      j_ff <= j_in; psi_ff <= psi_in; phase_ff <= phase_in; part_ff <= part_in;
      if (reset) begin
         state_ff <= ST_IDLE; h_ff <= '0; sum_ff <= '0; buf_ff <= '0; total_ff <= '0;
      end else begin
         state_ff <= state_in; h_ff <= h_in; sum_ff <= sum_in; buf_ff <= buf_in;
         total_ff <= total_in;
      end
   end

endmodule

// ===== bench/tb_gost_r3411_94_hash_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GOST R 34.11-94 hash engine testbench
// Drives messages of random length through the request port and checks each
// digest part against a behavioural hash model held in a scoreboard class.
// ----------------------------------------------------------------------------

class gost_digest_board;
   // model state
   logic [31:0] chain [8];
   logic [31:0] csum [8];
   logic [7:0]  buf_b [32];
   logic [63:0] nbytes;
   // expected digest parts: {part, index, last}
   logic [66:0] digest_q [$];
   int errors;

   function new();
      errors = 0;
      clear();
   endfunction

   function void clear();
      for (int i = 0; i < 8; i++) begin
         chain[i] = '0;
         csum[i] = '0;
      end
      for (int i = 0; i < 32; i++) buf_b[i] = '0;
      nbytes = '0;
   endfunction

   function logic [31:0] gost_round(logic [31:0] half, logic [31:0] k);
      int tab [8][16];
      logic [31:0] x;
      logic [31:0] y;
      tab = '{
         '{10,4,5,6,8,1,3,7,13,12,14,0,9,2,11,15},
         '{5,15,4,0,2,13,11,9,1,7,6,3,12,14,10,8},
         '{7,15,12,14,9,4,1,0,3,11,5,2,6,10,8,13},
         '{4,10,7,12,0,15,2,8,14,1,6,5,13,11,9,3},
         '{7,6,4,11,9,12,2,10,1,8,0,14,15,13,3,5},
         '{7,6,2,4,13,9,15,0,10,1,5,11,8,14,12,3},
         '{13,14,4,1,7,0,5,10,3,12,8,15,6,2,9,11},
         '{1,3,10,9,5,11,4,15,8,6,7,14,13,0,2,12}};
      x = half + k;
      for (int n = 0; n < 8; n++) y[4*n +: 4] = 4'(tab[n][x[4*n +: 4]]);
      return {y[20:0], y[31:21]};
   endfunction

   function void encrypt(logic [31:0] key [8], logic [31:0] lo, logic [31:0] hi,
                         output logic [31:0] olo, output logic [31:0] ohi);
      logic [31:0] a;
      logic [31:0] b;
      int i0;
      int i1;
      a = lo;
      b = hi;
      for (int r = 0; r < 32; r += 2) begin
         i0 = (r < 24) ? (r % 8) : (7 - (r % 8));
         i1 = (r < 24) ? ((r + 1) % 8) : (7 - ((r + 1) % 8));
         b ^= gost_round(a, key[i0]);
         a ^= gost_round(b, key[i1]);
      end
      olo = b;
      ohi = a;
   endfunction

   function void shift_a(ref logic [31:0] y [8]);
      logic [31:0] t0;
      logic [31:0] t1;
      t0 = y[0] ^ y[2];
      t1 = y[1] ^ y[3];
      for (int i = 0; i < 6; i++) y[i] = y[i+2];
      y[6] = t0;
      y[7] = t1;
   endfunction

   function void psi(ref logic [31:0] w [8]);
      logic [15:0] t;
      t = w[0][15:0] ^ w[0][31:16] ^ w[1][15:0] ^ w[1][31:16] ^ w[6][15:0]
          ^ w[7][31:16];
      for (int i = 0; i < 7; i++) w[i] = {w[i+1][15:0], w[i][31:16]};
      w[7] = {t, w[7][31:16]};
   endfunction

   function void compress(logic [31:0] m [8]);
      logic [31:0] c3 [8];
      logic [31:0] u [8];
      logic [31:0] v [8];
      logic [31:0] w [8];
      logic [31:0] key [8];
      logic [31:0] s [8];
      c3 = '{32'hff00ff00, 32'hff00ff00, 32'h00ff00ff, 32'h00ff00ff,
             32'h00ffff00, 32'hff0000ff, 32'h000000ff, 32'hff00ffff};
      u = chain;
      v = m;
      for (int j = 0; j < 4; j++) begin
         if (j > 0) begin
            shift_a(u);
            if (j == 2) for (int i = 0; i < 8; i++) u[i] ^= c3[i];
            shift_a(v);
            shift_a(v);
         end
         for (int i = 0; i < 8; i++) w[i] = u[i] ^ v[i];
         // key byte permutation
         for (int a = 0; a < 2; a++)
            for (int b = 0; b < 4; b++)
               for (int c = 0; c < 4; c++)
                  key[a*4+b][8*c +: 8] = w[2*c+a][8*b +: 8];
         encrypt(key, chain[2*j], chain[2*j+1], s[2*j], s[2*j+1]);
      end
      for (int i = 0; i < 12; i++) psi(s);
      for (int i = 0; i < 8; i++) s[i] ^= m[i];
      psi(s);
      for (int i = 0; i < 8; i++) s[i] ^= chain[i];
      for (int i = 0; i < 61; i++) psi(s);
      chain = s;
   endfunction

   function void absorb_block();
      logic [31:0] blk [8];
      logic [32:0] t;
      logic carry;
      carry = 1'b0;
      for (int i = 0; i < 8; i++) begin
         blk[i] = {buf_b[4*i+3], buf_b[4*i+2], buf_b[4*i+1], buf_b[4*i]};
         t = {1'b0, csum[i]} + {1'b0, blk[i]} + carry;
         csum[i] = t[31:0];
         carry = t[32];
      end
      compress(blk);
   endfunction

   // note one accepted request
   function void note_request(logic [63:0] data, logic [3:0] count, logic fin);
      int n;
      int pos;
      logic [31:0] len_blk [8];
      logic [63:0] bits;
      n = (count > 8) ? 8 : count;
      for (int i = 0; i < n; i++) begin
         pos = nbytes[4:0];
         buf_b[pos] = data[8*i +: 8];
         nbytes++;
         if (pos == 31) absorb_block();
      end
      if (!fin) return;
      pos = nbytes[4:0];
      if (pos > 0) begin
         for (int i = pos; i < 32; i++) buf_b[i] = '0;
         absorb_block();
      end
      bits = nbytes << 3;
      for (int i = 0; i < 8; i++) len_blk[i] = '0;
      len_blk[0] = bits[31:0];
      len_blk[1] = bits[63:32];
      compress(len_blk);
      compress(csum);
      for (int k = 0; k < 4; k++)
         digest_q.push_back({chain[2*k+1], chain[2*k], 2'(k), k == 3});
      clear();
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // check one digest part against the oldest expectation
   task check_part(logic [63:0] part, logic [1:0] idx, logic lp);
      logic [66:0] e;
      if (digest_q.size() == 0) begin
         report_mismatch("unexpected digest_part", part, '0);
         return;
      end
      e = digest_q.pop_front();
      if (part !== e[66:3]) report_mismatch("digest_part", part, e[66:3]);
      if (idx !== e[2:1]) report_mismatch("part_index", idx, e[2:1]);
      if (lp !== e[0]) report_mismatch("last_part", lp, e[0]);
   endtask
endclass

module tb_gost_r3411_94_hash_top;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_data_word;
   logic [3:0]  req_byte_count;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest_part;
   logic [1:0]  rsp_part_index;
   logic        rsp_last_part;

   gost_digest_board board;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_idle_pct;

   gost_r3411_94_hash_top dut (.*);

   // 10 ns clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Generous cap: up to 559 requests; even if every one finalised (three
   // compressions each, stalled digests) a run stays well under the
   // cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 2000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: random stall, checks on accept edges.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_part(rsp_digest_part, rsp_part_index, rsp_last_part);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one request and hold it until accepted.  Gaps are taken before
   // raising valid, so valid stays high across back-to-back requests.
   task automatic send_request(logic [63:0] data, logic [3:0] count, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= data;
      req_byte_count <= count;
      req_last       <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(data, count, fin);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.digest_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // A message of random length, ending in a last request.
   task automatic send_message(int max_items);
      int n;
      n = $urandom_range(max_items);
      for (int i = 0; i < n; i++)
         send_request(rand_word(), ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                          : 4'd8, 1'b0);
      send_request(rand_word(), 4'($urandom_range(15)), 1'b1);
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_byte_count = '0;
      req_last = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, a single empty last request
      send_request('0, 4'd0, 1'b1);
      // oversized count saturates to eight bytes
      send_request('1, 4'd15, 1'b1);
      send_request(64'h0123456789abcdef, 4'd9, 1'b1);
      // empty items in the middle, then exactly one full block
      send_request(rand_word(), 4'd0, 1'b0);
      for (int i = 0; i < 4; i++) send_request('1, 4'd8, 1'b0);
      send_request(rand_word(), 4'd0, 1'b1);
      // partial block then padded finish, all-zero data
      send_request('0, 4'd3, 1'b0);
      send_request('0, 4'd1, 1'b1);
      // two blocks of all-ones: carry ripples through the control sum
      for (int i = 0; i < 7; i++) send_request('1, 4'd8, 1'b0);
      send_request('1, 4'd8, 1'b1);
      // pause until every digest part has left the block
      drain();

      // Random messages under three idling profiles
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 20 : 0;
         for (int m = 0; m < 10; m++) send_message(17);
      end
      drain();

      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.digest_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== gost_r3411_94_hash_top.f =====
sv/gost_pkg.sv
sv/gost_cipher.sv
sv/gost_r3411_94_hash_top.sv
bench/tb_gost_r3411_94_hash_top.sv
